@@ design/qft_pkg.sv @@
// ----------------------------------------------------------------------------
// qft_pkg
// Types and character constants shared by the quoted field tokenizer.
// ----------------------------------------------------------------------------
package qft_pkg;

	localparam int unsigned ByteW = 8;

	localparam logic [ByteW-1:0] ChNul       = 8'h00;
	localparam logic [ByteW-1:0] ChHash      = 8'h23;
	localparam logic [ByteW-1:0] ChLBracket  = 8'h5b;
	localparam logic [ByteW-1:0] ChRBracket  = 8'h5d;
	localparam logic [ByteW-1:0] ChDQuote    = 8'h22;
	localparam logic [ByteW-1:0] ChSQuote    = 8'h27;
	localparam logic [ByteW-1:0] ChBackslash = 8'h5c;
	localparam logic [ByteW-1:0] ChNewline   = 8'h0a;
	localparam logic [ByteW-1:0] ChSpace     = 8'h20;
	localparam logic [ByteW-1:0] ChTab       = 8'h09;
	localparam logic [ByteW-1:0] ChCr        = 8'h0d;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_INDEX   = 3'd2,
		MODE_QUOTED  = 3'd3,
		MODE_BARE    = 3'd4,
		MODE_ESCAPE  = 3'd5
	} qft_mode_t;

	typedef struct packed {
		qft_mode_t mode;
		logic      quote_is_single;
	} qft_state_t;

	// up to two result bytes per input byte; the second is always the last
	typedef struct packed {
		logic [1:0]       count;
		logic [ByteW-1:0] data0;
		logic             last0;
		logic [ByteW-1:0] data1;
	} qft_result_t;

endpackage

@@ design/qft_classify.sv @@
// ----------------------------------------------------------------------------
// qft_classify
// Per-byte classifier: from the current byte and tokenizer state, works out
// the result bytes and the next state.
// ----------------------------------------------------------------------------
module qft_classify import qft_pkg::*; (
	input  logic [ByteW-1:0] data,
	input  qft_state_t       cur,
	output qft_state_t       nxt,
	output qft_result_t      res
);

	logic             is_ws;
	logic [ByteW-1:0] quote_ch;

	assign is_ws    = (data inside {ChSpace, [ChTab:ChCr]});
	assign quote_ch = cur.quote_is_single ? ChSQuote : ChDQuote;

	always_comb begin
		nxt       = cur;
		res.count = 2'd0;
		res.data0 = data;
		res.last0 = 1'b1;
		res.data1 = data;

		if (data == ChNul && cur.mode != MODE_ESCAPE) begin
			// nul passes through, state untouched
			res.count = 2'd1;
			res.data0 = ChNul;
		end else begin
			case (cur.mode)
				MODE_COMMENT: begin
					if (data == ChNewline) begin
						nxt.mode            = MODE_IDLE;
						nxt.quote_is_single = 1'b0;
					end
				end
				MODE_INDEX: begin
					if (data == ChNewline || data == ChRBracket) begin
						nxt.mode            = MODE_IDLE;
						nxt.quote_is_single = 1'b0;
					end
				end
				MODE_QUOTED: begin
					if (data == quote_ch) begin
						nxt.mode            = MODE_IDLE;
						nxt.quote_is_single = 1'b0;
						res.count           = 2'd1;
						res.data0           = ChNul;
					end else if (data == ChBackslash) begin
						nxt.mode = MODE_ESCAPE;
					end else begin
						res.count = 2'd1;
					end
				end
				MODE_ESCAPE: begin
					nxt.mode = MODE_QUOTED;
					if (data == quote_ch) begin
						res.count = 2'd1;
					end else begin
						// backslash kept, followed by the escaped byte
						res.count = 2'd2;
						res.data0 = ChBackslash;
						res.last0 = 1'b0;
					end
				end
				MODE_BARE: begin
					res.count = 2'd1;
					if (is_ws) begin
						nxt.mode            = MODE_IDLE;
						nxt.quote_is_single = 1'b0;
						res.data0           = ChNul;
					end
				end
				default: begin
					if (is_ws) begin
						nxt.mode = MODE_IDLE;
					end else if (data == ChHash) begin
						nxt.mode = MODE_COMMENT;
					end else if (data == ChLBracket) begin
						nxt.mode = MODE_INDEX;
					end else if (data == ChDQuote || data == ChSQuote) begin
						nxt.mode            = MODE_QUOTED;
						nxt.quote_is_single = (data == ChSQuote);
					end else begin
						nxt.mode            = MODE_BARE;
						nxt.quote_is_single = 1'b0;
						res.count           = 2'd1;
					end
				end
			endcase
		end
	end

endmodule

@@ design/quoted_field_tokenizer.sv @@
// ----------------------------------------------------------------------------
// quoted_field_tokenizer
// Splits a text byte stream into nul-terminated fields, skipping whitespace,
// comments and index markers, with quoted fields and escapes.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the output is not stalled. A byte is
// held in the input register while the classifier works on it, and its first
// result is then registered in the output buffer, from which it is transferred.
// Most bytes give zero or one result byte. An escaped byte other than the
// closing quote gives two, which leave one after the other. So the sustained
// rate is one byte per cycle except for those pairs, which hold the input back,
// and while the output is stalled. Bytes that give no result never wait on the
// output side.
module quoted_field_tokenizer import qft_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [ByteW-1:0] in_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [ByteW-1:0] out_byte,
	output logic             last_of_run
);

	logic             valid_s1;
	logic [ByteW-1:0] data_s1;
	qft_state_t       state_q;
	qft_state_t       state_nxt;
	qft_result_t      res;

	logic [1:0]       cnt_q;
	logic [ByteW-1:0] data0_q;
	logic             last0_q;
	logic [ByteW-1:0] data1_q;

	logic out_take;
	logic advance;
	logic load_s1;

	qft_classify u_classify (
		.data (data_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	assign out_valid   = (cnt_q != 2'd0);
	assign out_byte    = data0_q;
	assign last_of_run = last0_q;
	assign out_take    = out_valid && !out_stall;

	// a byte with results advances only once the buffer is empty after this edge
	assign advance  = valid_s1 && (res.count == 2'd0 || cnt_q == 2'd0 ||
		(cnt_q == 2'd1 && out_take));
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			data_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_IDLE, quote_is_single: 1'b0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (advance && res.count != 2'd0) begin
			cnt_q <= res.count;
		end else if (out_take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.count != 2'd0) begin
			data0_q <= res.data0;
			last0_q <= res.last0;
			data1_q <= res.data1;
		end else if (out_take && cnt_q == 2'd2) begin
			// second byte of a pair moves to the head
			data0_q <= data1_q;
			last0_q <= 1'b1;
		end
	end

endmodule

@@ tb/tb_quoted_field_tokenizer.sv @@
// ----------------------------------------------------------------------------
// tb_quoted_field_tokenizer
// Self-checking bench for the quoted field tokenizer: a directed run over the
// byte classes and escape cases, then random token streams (bare words,
// quoted fields with escapes, comments, index markers, whitespace, nul and
// noise), with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_quoted_field_tokenizer import qft_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumBytes   = 1300;
	localparam int IdleLimit  = 1000;
	localparam int DrainTicks = 6;

	// predicts the output byte stream and checks the results against it
	class token_scoreboard;
		qft_mode_t  mode;
		logic       quote_single;
		logic [8:0] expected_out[$]; // {last_of_run, out_byte}
		int         errors;

		function new();
			mode = MODE_IDLE;
			quote_single = 1'b0;
			errors = 0;
		endfunction

		static function bit is_space(logic [ByteW-1:0] c);
			return c == ChSpace || (c >= ChTab && c <= ChCr);
		endfunction

		function void push(logic [ByteW-1:0] b, logic last);
			expected_out.push_back({last, b});
		endfunction

		function void close_field();
			mode = MODE_IDLE;
			quote_single = 1'b0;
		endfunction

		function void tokenize_byte(logic [ByteW-1:0] c);
			logic [ByteW-1:0] q;
			q = quote_single ? ChSQuote : ChDQuote;
			if (c == ChNul && mode != MODE_ESCAPE) begin
				push(ChNul, 1'b1);
				return;
			end
			case (mode)
				MODE_COMMENT: begin
					if (c == ChNewline)
						close_field();
				end
				MODE_INDEX: begin
					if (c == ChNewline || c == ChRBracket)
						close_field();
				end
				MODE_QUOTED: begin
					if (c == q) begin
						close_field();
						push(ChNul, 1'b1);
					end else if (c == ChBackslash) begin
						mode = MODE_ESCAPE;
					end else begin
						push(c, 1'b1);
					end
				end
				MODE_ESCAPE: begin
					mode = MODE_QUOTED;
					if (c == q) begin
						push(c, 1'b1);
					end else begin
						push(ChBackslash, 1'b0);
						push(c, 1'b1);
					end
				end
				MODE_BARE: begin
					if (is_space(c)) begin
						close_field();
						push(ChNul, 1'b1);
					end else begin
						push(c, 1'b1);
					end
				end
				default: begin
					if (is_space(c)) begin
						mode = MODE_IDLE;
					end else if (c == ChHash) begin
						mode = MODE_COMMENT;
					end else if (c == ChLBracket) begin
						mode = MODE_INDEX;
					end else if (c == ChDQuote || c == ChSQuote) begin
						quote_single = (c == ChSQuote);
						mode = MODE_QUOTED;
					end else begin
						quote_single = 1'b0;
						mode = MODE_BARE;
						push(c, 1'b1);
					end
				end
			endcase
		endfunction

		function void check_output(logic [ByteW-1:0] b, logic last);
			logic [8:0] exp_item;
			if (expected_out.size() == 0) begin
				$error("unexpected result: out_byte %h last_of_run %b", b, last);
				errors++;
				return;
			end
			exp_item = expected_out.pop_front();
			if (b !== exp_item[7:0]) begin
				$error("out_byte: expected %h, got %h", exp_item[7:0], b);
				errors++;
			end
			if (last !== exp_item[8]) begin
				$error("last_of_run: expected %b, got %b", exp_item[8], last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_out.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [ByteW-1:0] in_byte = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [ByteW-1:0] out_byte;
	logic             last_of_run;

	token_scoreboard sb = new;
	bit              gaps_on = 1'b1;
	int              sent_bytes = 0;
	int              quiet_cycles = 0;

	quoted_field_tokenizer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= gaps_on && ($urandom_range(99) < 23);
	end

	// note each input transfer before checking the output one
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.tokenize_byte(in_byte);
		if (arst_n && out_valid && !out_stall)
			sb.check_output(out_byte, last_of_run);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IdleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_byte(input logic [ByteW-1:0] b);
		while (gaps_on && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_bytes++;
	endtask

	function automatic logic [ByteW-1:0] rand_byte_except(logic [ByteW-1:0] x0,
			logic [ByteW-1:0] x1, bit no_space);
		logic [ByteW-1:0] b;
		do
			b = ByteW'($urandom_range(255));
		while (b == x0 || b == x1 || (no_space && token_scoreboard::is_space(b)));
		return b;
	endfunction

	function automatic logic [ByteW-1:0] rand_space();
		logic [ByteW-1:0] b;
		if ($urandom_range(5) == 0)
			b = ChSpace;
		else
			b = ChTab + ByteW'($urandom_range(4));
		return b;
	endfunction

	task automatic send_token();
		int               kind;
		int               len;
		logic [ByteW-1:0] q;
		logic [ByteW-1:0] b;
		kind = $urandom_range(99);
		if (kind < 30) begin
			// bare word, first byte must not open anything else
			do
				b = ByteW'($urandom_range(255));
			while (b == ChNul || b == ChHash || b == ChLBracket || b == ChDQuote ||
				b == ChSQuote || token_scoreboard::is_space(b));
			send_byte(b);
			len = $urandom_range(5);
			repeat (len)
				send_byte(rand_byte_except(ChNul, ChNul, 1'b1));
			send_byte(rand_space());
		end else if (kind < 55) begin
			q = $urandom_range(1) ? ChSQuote : ChDQuote;
			send_byte(q);
			len = $urandom_range(8);
			repeat (len) begin
				if ($urandom_range(3) == 0) begin
					send_byte(ChBackslash);
					send_byte($urandom_range(1) ? q : ByteW'($urandom_range(255)));
				end else begin
					send_byte(rand_byte_except(q, ChBackslash, 1'b0));
				end
			end
			send_byte(q);
		end else if (kind < 65) begin
			send_byte(ChHash);
			len = $urandom_range(6);
			repeat (len)
				send_byte(rand_byte_except(ChNewline, ChNewline, 1'b0));
			send_byte(ChNewline);
		end else if (kind < 75) begin
			send_byte(ChLBracket);
			len = $urandom_range(3);
			repeat (len)
				send_byte(rand_byte_except(ChRBracket, ChNewline, 1'b0));
			send_byte($urandom_range(1) ? ChRBracket : ChNewline);
		end else if (kind < 87) begin
			len = $urandom_range(1, 3);
			repeat (len)
				send_byte(rand_space());
		end else if (kind < 92) begin
			send_byte(ChNul);
		end else begin
			// noise, may leave a field or skip open
			send_byte(ByteW'($urandom_range(255)));
		end
	endtask

	initial begin
		logic [ByteW-1:0] directed[$];
		directed = '{
			ChNul,                                         // nul between fields
			8'hff, ChNul, ChSpace,                         // bare field, nul inside
			ChHash, ChNul, ChNewline,                      // comment with nul
			ChLBracket, ChNewline, ChLBracket, ChRBracket, // index markers
			ChSQuote, ChDQuote, ChBackslash, ChSQuote,     // escaped single quote
			ChBackslash, ChNul, ChSQuote,                  // nul after backslash
			ChDQuote, ChBackslash, 8'h78,                  // plain escape
			ChBackslash, ChDQuote, ChDQuote                // escaped then closing quote
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_byte(directed[i]);
		while (sent_bytes < NumBytes) begin
			// long stretch with no gaps or stalls in the middle of the run
			gaps_on = !(sent_bytes >= 500 && sent_bytes < 800);
			send_token();
		end
		in_valid <= 1'b0;
		gaps_on = 1'b1;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DrainTicks) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
